>>> rtl/wbp_pkg.sv
// ----------------------------------------------------------------------------
// wbp_pkg
// Shared widths, codes, reset values and the configuration struct of the
// white balance pixel pipe.
// ----------------------------------------------------------------------------
package wbp_pkg;

   // fixed field widths
   localparam int CH_W         = 16;
   localparam int CURVE_ADDR_W = 16;
   localparam int CURVE_GAIN_W = 32;
   localparam int GAIN_W       = 16;
   localparam int SAT_W        = 14;
   localparam int LEVEL_W      = 17;
   localparam int CSR_IDX_W    = 4;
   localparam int CSR_DATA_W   = 17;

   // fixed point
   localparam int FRAC_BITS   = 12;
   localparam int CURVE_FRAC  = 16;
   localparam int CURVE_SHIFT = FRAC_BITS + CURVE_FRAC;
   localparam int BYTE_SCALE  = 256;

   // parameter defaults
   localparam int CURVE_DEPTH_DEF = 65536;
   localparam int SAMPLE_BITS_DEF = 16;

   // item opcodes
   localparam logic OP_PIXEL    = 1'b0;
   localparam logic OP_CURVE_WR = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_RED    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_GREEN  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_BLUE   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SATURATION  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLACK_LEVEL = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WHITE_LEVEL = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDE_MODE   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_OVX_MARK    = 4'd7;

   // reset values
   localparam logic [GAIN_W-1:0]  GAIN_ONE    = 16'd4096;
   localparam logic [SAT_W-1:0]   SAT_RESET   = 14'd4096;
   localparam logic [LEVEL_W-1:0] BLACK_RESET = 17'd0;
   localparam logic [LEVEL_W-1:0] WHITE_RESET = 17'd65536;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_red;
      logic [GAIN_W-1:0]  gain_green;
      logic [GAIN_W-1:0]  gain_blue;
      logic [SAT_W-1:0]   saturation;
      logic [LEVEL_W-1:0] black_level;
      logic [LEVEL_W-1:0] white_level;
      logic               wide_mode;
      logic               ovx_mark;
   } cfg_type;

endpackage

>>> rtl/wbp_if.sv
// ----------------------------------------------------------------------------
// wbp_if
// Valid/ready channels of the pixel pipe: request, response and register
// write.
// ----------------------------------------------------------------------------
interface wbp_req_if import wbp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    opcode;
   logic [CH_W-1:0]         in_blue;
   logic [CH_W-1:0]         in_green;
   logic [CH_W-1:0]         in_red;
   logic                    frame_last;
   logic [CURVE_ADDR_W-1:0] curve_address;
   logic [CURVE_GAIN_W-1:0] curve_gain;

   modport source (output valid, opcode, in_blue, in_green, in_red, frame_last,
                   curve_address, curve_gain, input ready);
   modport sink (input valid, opcode, in_blue, in_green, in_red, frame_last,
                 curve_address, curve_gain, output ready);
endinterface

interface wbp_rsp_if import wbp_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] out_blue;
   logic [CH_W-1:0] out_green;
   logic [CH_W-1:0] out_red;
   logic            frame_last_out;

   modport source (output valid, out_blue, out_green, out_red, frame_last_out,
                   input ready);
   modport sink (input valid, out_blue, out_green, out_red, frame_last_out,
                 output ready);
endinterface

interface wbp_csr_if import wbp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/wbp_ram.sv
// ----------------------------------------------------------------------------
// wbp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module wbp_ram import wbp_pkg::*; #(
   parameter int WIDTH = CURVE_GAIN_W,
   parameter int DEPTH = CURVE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/wbp_csr.sv
// ----------------------------------------------------------------------------
// wbp_csr
// Configuration registers, written one at a time over the register channel.
// ----------------------------------------------------------------------------
module wbp_csr import wbp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GAIN_RED:    cfg_in.gain_red    = csr_data[GAIN_W-1:0];
            CSR_GAIN_GREEN:  cfg_in.gain_green  = csr_data[GAIN_W-1:0];
            CSR_GAIN_BLUE:   cfg_in.gain_blue   = csr_data[GAIN_W-1:0];
            CSR_SATURATION:  cfg_in.saturation  = csr_data[SAT_W-1:0];
            CSR_BLACK_LEVEL: cfg_in.black_level = csr_data[LEVEL_W-1:0];
            CSR_WHITE_LEVEL: cfg_in.white_level = csr_data[LEVEL_W-1:0];
            CSR_WIDE_MODE:   cfg_in.wide_mode   = csr_data[0];
            CSR_OVX_MARK:    cfg_in.ovx_mark    = csr_data[0];
            // indexes past the list are dropped
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_red    <= GAIN_ONE;
         cfg_ff.gain_green  <= GAIN_ONE;
         cfg_ff.gain_blue   <= GAIN_ONE;
         cfg_ff.saturation  <= SAT_RESET;
         cfg_ff.black_level <= BLACK_RESET;
         cfg_ff.white_level <= WHITE_RESET;
         cfg_ff.wide_mode   <= 1'b1;
         cfg_ff.ovx_mark    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

>>> rtl/wbp_front.sv
// ----------------------------------------------------------------------------
// wbp_front
// Stages one and two: per-channel gain multiply, then channel maximum,
// clipping, over-exposure marking and curve index.
// ----------------------------------------------------------------------------
module wbp_front import wbp_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int CURVE_DEPTH = CURVE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cfg_type                          cfg,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_opcode,
   input  logic [2:0][CH_W-1:0]             req_sample,
   input  logic                             req_frame_last,
   input  logic [CURVE_ADDR_W-1:0]          req_curve_address,
   input  logic [CURVE_GAIN_W-1:0]          req_curve_gain,
   output logic                             s2_valid,
   input  logic                             s2_ready,
   output logic                             s2_opcode,
   output logic                             s2_frame_last,
   output logic [CURVE_ADDR_W-1:0]          s2_curve_address,
   output logic [CURVE_GAIN_W-1:0]          s2_curve_gain,
   output logic [SAMPLE_BITS-1:0]           s2_value,
   output logic [2:0][SAMPLE_BITS:0]        s2_chan,
   output logic [$clog2(CURVE_DEPTH)-1:0]   s2_idx
);

   localparam int SB     = SAMPLE_BITS;
   localparam int SCL_W  = SB + GAIN_W - FRAC_BITS;
   localparam int CLIP_W = SB + 1;
   localparam int AW     = $clog2(CURVE_DEPTH);
   localparam int CMP_W  = (SCL_W > LEVEL_W) ? SCL_W : LEVEL_W;
   localparam logic [SB-1:0]      FULL_M1  = {SB{1'b1}};
   localparam logic [SB-1:0]      BYTE_M1  = SB'(BYTE_SCALE - 1);
   localparam logic [LEVEL_W-1:0] LAST_IDX = LEVEL_W'(CURVE_DEPTH - 1);

   // stage 1
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_opcode_ff, s1_opcode_in;
   logic                     s1_last_ff, s1_last_in;
   logic [CURVE_ADDR_W-1:0]  s1_addr_ff, s1_addr_in;
   logic [CURVE_GAIN_W-1:0]  s1_gain_ff, s1_gain_in;
   logic [2:0][SCL_W-1:0]    s1_scaled_ff, s1_scaled_in;

   // stage 2
   logic                     s2_valid_ff, s2_valid_in;
   logic                     s2_opcode_ff;
   logic                     s2_last_ff;
   logic [CURVE_ADDR_W-1:0]  s2_addr_ff;
   logic [CURVE_GAIN_W-1:0]  s2_gain_ff;
   logic [SB-1:0]            s2_value_ff, s2_value_in;
   logic [2:0][CLIP_W-1:0]   s2_chan_ff, s2_chan_in;
   logic [AW-1:0]            s2_idx_ff, s2_idx_in;

   logic                     s1_en;
   logic                     s2_free;
   logic [2:0][GAIN_W-1:0]   gain_sel;
   logic [2:0][SB+GAIN_W-1:0] mul_w;
   logic [SB-1:0]            fs_m1;
   logic [CLIP_W-1:0]        fs;
   logic [SCL_W-1:0]         chan_max;
   logic                     mark;

   assign s2_free   = !s2_valid_ff || s2_ready;
   assign s1_en     = !s1_valid_ff || s2_free;
   assign req_ready = s1_en;

   assign fs_m1 = cfg.wide_mode ? FULL_M1 : BYTE_M1;
   assign fs    = {1'b0, fs_m1} + CLIP_W'(1);

   // gain multiply, channel order blue, green, red
   always_comb begin
      gain_sel[0] = cfg.gain_blue;
      gain_sel[1] = cfg.gain_green;
      gain_sel[2] = cfg.gain_red;
      for (int c = 0; c < 3; c++) begin
         mul_w[c]        = req_sample[c][SB-1:0] * gain_sel[c];
         s1_scaled_in[c] = mul_w[c][SB+GAIN_W-1:FRAC_BITS];
      end
      s1_valid_in  = req_valid;
      s1_opcode_in = req_opcode;
      s1_last_in   = req_frame_last;
      s1_addr_in   = req_curve_address;
      s1_gain_in   = req_curve_gain;
   end

   // maximum, clip, marking
   always_comb begin
      chan_max = s1_scaled_ff[0];
      if (s1_scaled_ff[1] > chan_max) begin
         chan_max = s1_scaled_ff[1];
      end
      if (s1_scaled_ff[2] > chan_max) begin
         chan_max = s1_scaled_ff[2];
      end
      s2_value_in = (chan_max > SCL_W'(fs_m1)) ? fs_m1 : chan_max[SB-1:0];
      mark = cfg.ovx_mark && (LEVEL_W'(s2_value_in) > cfg.black_level)
                          && (LEVEL_W'(s2_value_in) > cfg.white_level);
      for (int c = 0; c < 3; c++) begin
         s2_chan_in[c] = (s1_scaled_ff[c] > SCL_W'(fs)) ? fs
                                                        : CLIP_W'(s1_scaled_ff[c]);
         if (mark && (CMP_W'(s1_scaled_ff[c]) > CMP_W'(cfg.white_level))) begin
            s2_chan_in[c] = '0;
         end
      end
      s2_idx_in   = (LEVEL_W'(s2_value_in) > LAST_IDX) ? AW'(LAST_IDX)
                                                       : AW'(s2_value_in);
      s2_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= s1_valid_in;
         end
         if (s2_free) begin
            s2_valid_ff <= s2_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_opcode_ff <= s1_opcode_in;
         s1_last_ff   <= s1_last_in;
         s1_addr_ff   <= s1_addr_in;
         s1_gain_ff   <= s1_gain_in;
         s1_scaled_ff <= s1_scaled_in;
      end
      if (s2_free) begin
         s2_opcode_ff <= s1_opcode_ff;
         s2_last_ff   <= s1_last_ff;
         s2_addr_ff   <= s1_addr_ff;
         s2_gain_ff   <= s1_gain_ff;
         s2_value_ff  <= s2_value_in;
         s2_chan_ff   <= s2_chan_in;
         s2_idx_ff    <= s2_idx_in;
      end
   end

   assign s2_valid         = s2_valid_ff;
   assign s2_opcode        = s2_opcode_ff;
   assign s2_frame_last    = s2_last_ff;
   assign s2_curve_address = s2_addr_ff;
   assign s2_curve_gain    = s2_gain_ff;
   assign s2_value         = s2_value_ff;
   assign s2_chan          = s2_chan_ff;
   assign s2_idx           = s2_idx_ff;

   // a stalled first stage keeps its transaction
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_free |=> s1_valid_ff)
      else $error("stage one lost a stalled transaction");

endmodule

>>> rtl/wbp_back.sv
// ----------------------------------------------------------------------------
// wbp_back
// Stages three to five: curve table access, saturation mix, curve gain
// multiply, then shift, clamp and the output register.
// ----------------------------------------------------------------------------
module wbp_back import wbp_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int CURVE_DEPTH = CURVE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cfg_type                        cfg,
   input  logic                           s2_valid,
   output logic                           s2_ready,
   input  logic                           s2_opcode,
   input  logic                           s2_frame_last,
   input  logic [CURVE_ADDR_W-1:0]        s2_curve_address,
   input  logic [CURVE_GAIN_W-1:0]        s2_curve_gain,
   input  logic [SAMPLE_BITS-1:0]         s2_value,
   input  logic [2:0][SAMPLE_BITS:0]      s2_chan,
   input  logic [$clog2(CURVE_DEPTH)-1:0] s2_idx,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [2:0][CH_W-1:0]           rsp_sample,
   output logic                           rsp_frame_last
);

   localparam int SB     = SAMPLE_BITS;
   localparam int AW     = $clog2(CURVE_DEPTH);
   localparam int TERM_W = SB + FRAC_BITS + 5;
   localparam int MAG_W  = SB + FRAC_BITS + 1;
   localparam int PROD_W = MAG_W + CURVE_GAIN_W;
   localparam int Q_W    = PROD_W - CURVE_SHIFT;
   localparam logic [SB-1:0] FULL_M1 = {SB{1'b1}};
   localparam logic [SB-1:0] BYTE_M1 = SB'(BYTE_SCALE - 1);

   logic                      s3_valid_ff, s3_valid_in;
   logic                      s3_last_ff;
   logic signed [TERM_W-1:0]  s3_term_ff [3];
   logic signed [TERM_W-1:0]  s3_term_in [3];

   logic                      s4_valid_ff;
   logic                      s4_last_ff;
   logic [2:0]                s4_pos_ff, s4_pos_in;
   logic [PROD_W-1:0]         s4_prod_ff [3];
   logic [PROD_W-1:0]         s4_prod_in [3];

   logic                      out_valid_ff;
   logic                      out_last_ff;
   logic [2:0][CH_W-1:0]      out_sample_ff, out_sample_in;

   logic                      out_free, s4_free, s3_free;
   logic                      ram_we, ram_re;
   logic [CURVE_GAIN_W-1:0]   ram_rdata;
   logic signed [SB+1:0]      diff [3];
   logic signed [TERM_W-1:0]  mix [3];
   logic [MAG_W-1:0]          mag [3];
   logic [Q_W-1:0]            q [3];
   logic [SB-1:0]             fs_m1;

   assign out_free = !out_valid_ff || rsp_ready;
   assign s4_free  = !s4_valid_ff || out_free;
   assign s3_free  = !s3_valid_ff || s4_free;
   assign s2_ready = s3_free;

   assign fs_m1 = cfg.wide_mode ? FULL_M1 : BYTE_M1;

   // table writes and reads happen at the same stage, so they stay in order
   assign ram_we = s3_free && s2_valid && (s2_opcode == OP_CURVE_WR)
                   && ((LEVEL_W'(s2_curve_address)) < LEVEL_W'(CURVE_DEPTH));
   assign ram_re = s3_free && s2_valid && (s2_opcode == OP_PIXEL);
   assign s3_valid_in = s2_valid && (s2_opcode == OP_PIXEL);

   wbp_ram #(
      .WIDTH (CURVE_GAIN_W),
      .DEPTH (CURVE_DEPTH)
   ) u_curve_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (AW'(s2_curve_address)),
      .wdata (s2_curve_gain),
      .re    (ram_re),
      .raddr (s2_idx),
      .rdata (ram_rdata)
   );

   // value*4096 - sat*(value - chan)
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         diff[c] = $signed({2'b00, s2_value}) - $signed({1'b0, s2_chan[c]});
         mix[c]  = $signed({1'b0, cfg.saturation}) * diff[c];
         s3_term_in[c] = $signed(TERM_W'({s2_value, {FRAC_BITS{1'b0}}})) - mix[c];
      end
   end

   // curve gain multiply, a non-positive mix term ends at zero
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s4_pos_in[c]  = s3_term_ff[c] > $signed(TERM_W'(0));
         mag[c]        = s3_term_ff[c][MAG_W-1:0];
         s4_prod_in[c] = mag[c] * ram_rdata;
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         q[c] = s4_prod_ff[c][PROD_W-1:CURVE_SHIFT];
         if (!s4_pos_ff[c]) begin
            out_sample_in[c] = '0;
         end else if (q[c] > Q_W'(fs_m1)) begin
            out_sample_in[c] = CH_W'(fs_m1);
         end else begin
            out_sample_in[c] = CH_W'(q[c][SB-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s3_free) begin
            s3_valid_ff <= s3_valid_in;
         end
         if (s4_free) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (out_free) begin
            out_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_free) begin
         s3_last_ff <= s2_frame_last;
         s3_term_ff <= s3_term_in;
      end
      if (s4_free) begin
         s4_last_ff <= s3_last_ff;
         s4_pos_ff  <= s4_pos_in;
         s4_prod_ff <= s4_prod_in;
      end
      if (out_free) begin
         out_last_ff   <= s4_last_ff;
         out_sample_ff <= out_sample_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample     = out_sample_ff;
   assign rsp_frame_last = out_last_ff;

   a_ram_one_op: assert property (@(posedge clock) !(ram_we && ram_re))
      else $error("curve table written and read in one cycle");

   a_nonpos_zero: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && out_free && !s4_pos_ff[0]
      |=> out_valid_ff && (out_sample_ff[0] == '0))
      else $error("non-positive mix term did not give zero");

endmodule

>>> rtl/white_balance_pixel_pipe_core.sv
// ----------------------------------------------------------------------------
// white_balance_pixel_pipe_core
// White balance gain, tone-curve table lookup and saturation mix on a BGR
// pixel stream.
// ----------------------------------------------------------------------------
// Use:
//   req_ch carries one transaction per pixel (opcode pixel) or per tone-curve
//   entry load (opcode curve write). Load every curve entry a pixel can index
//   before sending pixels; the table is not cleared by reset.
//   rsp_ch returns one corrected pixel per pixel transaction, in order,
//   with frame_last_out copied through; curve loads return nothing.
//   csr_ch writes one configuration register per transaction; write only
//   while no pixel is in flight. csr_ch is always ready.
// Timing:
//   five register stages (gain multiply, max/clip, table read and mix
//   multiply, curve multiply, clamp/output). One transaction per cycle is
//   sustained while rsp_ch is ready; the curve table port handles one
//   access per cycle.
// Reset and stall:
//   reset empties the pipeline and loads register defaults. A stalled rsp_ch
//   holds the output; earlier stages keep filling bubbles, and req_ch ready
//   drops only once all five stages are occupied.
// ----------------------------------------------------------------------------
module white_balance_pixel_pipe_core import wbp_pkg::*; #(
   parameter int CURVE_DEPTH = CURVE_DEPTH_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   wbp_req_if.sink      req_ch,
   wbp_rsp_if.source    rsp_ch,
   wbp_csr_if.sink      csr_ch
);

   localparam int AW = $clog2(CURVE_DEPTH);

   cfg_type                       cfg;
   logic [2:0][CH_W-1:0]          req_sample;
   logic                          s2_valid, s2_ready, s2_opcode, s2_frame_last;
   logic [CURVE_ADDR_W-1:0]       s2_curve_address;
   logic [CURVE_GAIN_W-1:0]       s2_curve_gain;
   logic [SAMPLE_BITS-1:0]        s2_value;
   logic [2:0][SAMPLE_BITS:0]     s2_chan;
   logic [AW-1:0]                 s2_idx;
   logic                          rsp_valid, rsp_frame_last;
   logic [2:0][CH_W-1:0]          rsp_sample;

   assign req_sample[0] = req_ch.in_blue;
   assign req_sample[1] = req_ch.in_green;
   assign req_sample[2] = req_ch.in_red;

   wbp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_ch.valid),
      .csr_ready (csr_ch.ready),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .cfg       (cfg)
   );

   wbp_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CURVE_DEPTH (CURVE_DEPTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .req_opcode        (req_ch.opcode),
      .req_sample        (req_sample),
      .req_frame_last    (req_ch.frame_last),
      .req_curve_address (req_ch.curve_address),
      .req_curve_gain    (req_ch.curve_gain),
      .s2_valid          (s2_valid),
      .s2_ready          (s2_ready),
      .s2_opcode         (s2_opcode),
      .s2_frame_last     (s2_frame_last),
      .s2_curve_address  (s2_curve_address),
      .s2_curve_gain     (s2_curve_gain),
      .s2_value          (s2_value),
      .s2_chan           (s2_chan),
      .s2_idx            (s2_idx)
   );

   wbp_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CURVE_DEPTH (CURVE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .s2_valid         (s2_valid),
      .s2_ready         (s2_ready),
      .s2_opcode        (s2_opcode),
      .s2_frame_last    (s2_frame_last),
      .s2_curve_address (s2_curve_address),
      .s2_curve_gain    (s2_curve_gain),
      .s2_value         (s2_value),
      .s2_chan          (s2_chan),
      .s2_idx           (s2_idx),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_sample       (rsp_sample),
      .rsp_frame_last   (rsp_frame_last)
   );

   assign rsp_ch.valid          = rsp_valid;
   assign rsp_ch.out_blue       = rsp_sample[0];
   assign rsp_ch.out_green      = rsp_sample[1];
   assign rsp_ch.out_red        = rsp_sample[2];
   assign rsp_ch.frame_last_out = rsp_frame_last;

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_ch.valid)
      else $error("response valid right after reset");

endmodule
